/* design/clb2d_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// clb2d_pkg
// Shared types and field widths of the 2-D linked-cell list builder.
// ----------------------------------------------------------------------------
package clb2d_pkg;

    // fixed field widths
    localparam int COORD_W   = 32;  // Q16.16 coordinates and config words
    localparam int MESH_W    = 8;   // mesh_size register
    localparam int RC_W      = 7;   // cell column / row fields
    localparam int NUM_W     = 16;  // particle number field
    localparam int LINK_W    = 17;  // link field and stored head
    localparam int CFG_IDX_W = 2;   // config register index

    // empty cell marker (-1 in LINK_W bits)
    localparam logic [LINK_W-1:0] NO_HEAD = '1;

    // request operation
    typedef enum logic [1:0] {
        MODE_CLEAR  = 2'd0,
        MODE_INSERT = 2'd1,
        MODE_QUERY  = 2'd2,
        MODE_NOP    = 2'd3
    } t_mode;

    // config register index
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BOX_MIN    = 2'd0,
        CFG_CELL_SCALE = 2'd1,
        CFG_MESH_SIZE  = 2'd2,
        CFG_UNUSED     = 2'd3
    } t_cfg_idx;

endpackage
`default_nettype wire

/* design/clb2d_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// clb2d_ram
// Generic single-write, single-read synchronous RAM, registered read data.
// ----------------------------------------------------------------------------
module clb2d_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 16384,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_we,
    input  wire logic [AW-1:0]           i_waddr,
    input  wire logic [WIDTH-1:0]        i_wdata,
    input  wire logic                    i_re,
    input  wire logic [AW-1:0]           i_raddr,
    output logic      [WIDTH-1:0]        o_rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    // read port, data held while not enabled
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

/* design/cell_list_binning_2d_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cell_list_binning_2d_core
// 2-D linked-cell list builder: bins particles into a square mesh and keeps
// one head per cell in a RAM, handing back the previous head as the link.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (i_in_valid / o_in_ready) carries mode, x/y position and
//   query cell. Result channel (o_out_valid / i_out_ready) returns one result
//   per request. Config channel (i_cfg_valid / o_cfg_ready) writes box_min,
//   cell_scale or mesh_size by index; it is always ready.
// Path: a request passes stages A, B, C and D, then the result register.
// Throughput: one insert or query per cycle unless stalled or clearing. The head
//   table is a RAM with registered read data; an insert reads the head and writes
//   itself back one stage later, with a bypass when back-to-back requests hit the same cell.
// Clear: once a clear request reaches the last stage, the table is swept one
//   entry per cycle, all MESH_MAX*MESH_MAX entries (16384 by default); no request
//   is taken from the clear's arrival until the sweep ends.
// Reset: config returns to its defaults, the particle count to zero, and the
//   same sweep runs before the first request is taken.
// Stall: while a result waits on i_out_ready the whole pipeline holds.
// ----------------------------------------------------------------------------
module cell_list_binning_2d_core #(
    parameter int MESH_MAX      = 128,
    parameter int MAX_PARTICLES = 65536
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // config write
    input  wire logic                                i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  wire logic [clb2d_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [clb2d_pkg::COORD_W-1:0]       i_cfg_data,
    // request
    input  wire logic                                i_in_valid,
    output logic                                     o_in_ready,
    input  wire logic [1:0]                          i_mode,
    input  wire logic signed [clb2d_pkg::COORD_W-1:0] i_x_pos,
    input  wire logic signed [clb2d_pkg::COORD_W-1:0] i_y_pos,
    input  wire logic [clb2d_pkg::RC_W-1:0]          i_query_x,
    input  wire logic [clb2d_pkg::RC_W-1:0]          i_query_y,
    // result
    output logic                                     o_out_valid,
    input  wire logic                                i_out_ready,
    output logic [clb2d_pkg::NUM_W-1:0]              o_particle_number,
    output logic [clb2d_pkg::RC_W-1:0]               o_cell_col,
    output logic [clb2d_pkg::RC_W-1:0]               o_cell_row,
    output logic signed [clb2d_pkg::LINK_W-1:0]      o_link,
    output logic                                     o_full_res
);
    import clb2d_pkg::*;

    localparam int CELLS = MESH_MAX * MESH_MAX;
    localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int CW    = (MESH_MAX > 1) ? $clog2(MESH_MAX) : 1;
    localparam int CNT_W = $clog2(MAX_PARTICLES + 1);

    // ------------------------------------------------------------------
    // config registers
    // ------------------------------------------------------------------
    logic signed [COORD_W-1:0] r_box_min;
    logic [COORD_W-1:0]        r_cell_scale;
    logic [MESH_W-1:0]         r_mesh_size;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_box_min    <= '0;
            r_cell_scale <= COORD_W'(65536);
            r_mesh_size  <= MESH_W'(1);
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_BOX_MIN:    r_box_min    <= i_cfg_data;
                CFG_CELL_SCALE: r_cell_scale <= i_cfg_data;
                CFG_MESH_SIZE:  r_mesh_size  <= i_cfg_data[MESH_W-1:0];
                default:        ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // pipeline control
    // ------------------------------------------------------------------
    logic en;           // whole pipeline advances
    logic clr_pend;     // a clear is in flight
    logic in_take;

    logic          r_a_vld, r_b_vld, r_d_vld;
    t_mode         r_a_mode, r_b_mode, r_d_mode;
    logic          r_clr_busy;
    logic [AW-1:0] r_clr_addr;
    logic [CNT_W-1:0] r_count;
    logic          r_out_vld;

    assign en       = !r_out_vld || i_out_ready;
    assign clr_pend = (r_a_vld && r_a_mode == MODE_CLEAR)
                   || (r_b_vld && r_b_mode == MODE_CLEAR)
                   || (r_d_vld && r_d_mode == MODE_CLEAR);
    assign o_in_ready = en && !r_clr_busy && !clr_pend;
    assign in_take    = i_in_valid && o_in_ready;

    // ------------------------------------------------------------------
    // stage A: offset from box edge
    // ------------------------------------------------------------------
    logic signed [COORD_W:0] dx, dy;
    logic                    r_a_px, r_a_py;   // offset strictly positive
    logic [COORD_W-1:0]      r_a_dx, r_a_dy;
    logic [RC_W-1:0]         r_a_qx, r_a_qy;

    assign dx = {i_x_pos[COORD_W-1], i_x_pos} - {r_box_min[COORD_W-1], r_box_min};
    assign dy = {i_y_pos[COORD_W-1], i_y_pos} - {r_box_min[COORD_W-1], r_box_min};

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_mode <= t_mode'(i_mode);
            r_a_px   <= (dx > 0);
            r_a_py   <= (dy > 0);
            r_a_dx   <= dx[COORD_W-1:0];
            r_a_dy   <= dy[COORD_W-1:0];
            r_a_qx   <= i_query_x;
            r_a_qy   <= i_query_y;
        end
    end

    // ------------------------------------------------------------------
    // stage B: scale, integer part of Q32.32 product
    // ------------------------------------------------------------------
    logic [2*COORD_W-1:0] prod_x, prod_y;
    logic                 r_b_px, r_b_py;
    logic [COORD_W-1:0]   r_b_hx, r_b_hy;
    logic [RC_W-1:0]      r_b_qx, r_b_qy;

    assign prod_x = r_a_dx * r_cell_scale;
    assign prod_y = r_a_dy * r_cell_scale;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_b_mode <= r_a_mode;
            r_b_px   <= r_a_px;
            r_b_py   <= r_a_py;
            r_b_hx   <= prod_x[2*COORD_W-1:COORD_W];
            r_b_hy   <= prod_y[2*COORD_W-1:COORD_W];
            r_b_qx   <= r_a_qx;
            r_b_qy   <= r_a_qy;
        end
    end

    // ------------------------------------------------------------------
    // stage C: clamp to mesh, table address, head read
    // ------------------------------------------------------------------
    logic [MESH_W-1:0] last;
    logic [MESH_W-1:0] idx_x, idx_y;
    logic [CW-1:0]     col, row;
    logic              q_in_tab;
    logic [AW-1:0]     c_addr;
    logic [RC_W-1:0]   c_col7, c_row7;

    always_comb begin
        // last usable cell index of the effective mesh
        if (r_mesh_size == '0) begin
            last = '0;
        end else if ({1'b0, r_mesh_size} > (MESH_W + 1)'(MESH_MAX)) begin
            last = MESH_W'(MESH_MAX - 1);
        end else begin
            last = r_mesh_size - MESH_W'(1);
        end

        if (!r_b_px) begin
            idx_x = '0;
        end else if (r_b_hx > COORD_W'(last)) begin
            idx_x = last;
        end else begin
            idx_x = r_b_hx[MESH_W-1:0];
        end
        if (!r_b_py) begin
            idx_y = '0;
        end else if (r_b_hy > COORD_W'(last)) begin
            idx_y = last;
        end else begin
            idx_y = r_b_hy[MESH_W-1:0];
        end
        col = CW'(idx_x);
        row = CW'(idx_y);

        q_in_tab = (32'(r_b_qx) < MESH_MAX) && (32'(r_b_qy) < MESH_MAX);

        if (r_b_mode == MODE_QUERY) begin
            c_addr = AW'(r_b_qx) * AW'(MESH_MAX) + AW'(r_b_qy);
            c_col7 = r_b_qx;
            c_row7 = r_b_qy;
        end else begin
            c_addr = AW'(col) * AW'(MESH_MAX) + AW'(row);
            c_col7 = RC_W'(col);
            c_row7 = RC_W'(row);
        end
    end

    logic [AW-1:0]   r_d_addr;
    logic [RC_W-1:0] r_d_col, r_d_row;
    logic            r_d_inq;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_d_mode <= r_b_mode;
        end
    end

    // C stage payload is the B stage result, registered into D
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_d_addr <= c_addr;
            r_d_col  <= c_col7;
            r_d_row  <= c_row7;
            r_d_inq  <= q_in_tab;
        end
    end

    // ------------------------------------------------------------------
    // head table
    // ------------------------------------------------------------------
    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [LINK_W-1:0] ram_wdata;
    logic [LINK_W-1:0] ram_rdata;
    logic              d_write;
    logic              d_full;

    clb2d_ram #(
        .WIDTH (LINK_W),
        .DEPTH (CELLS)
    ) u_heads (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (en),
        .i_raddr (c_addr),
        .o_rdata (ram_rdata)
    );

    // ------------------------------------------------------------------
    // stage D: read-modify-write of the head, result
    // ------------------------------------------------------------------
    logic              r_fwd_vld;
    logic [AW-1:0]     r_fwd_addr;
    logic [LINK_W-1:0] r_fwd_data;
    logic [LINK_W-1:0] head;

    // bypass the write made by the request just ahead
    assign head   = (r_fwd_vld && r_fwd_addr == r_d_addr) ? r_fwd_data : ram_rdata;
    assign d_full = (r_count == CNT_W'(MAX_PARTICLES));
    assign d_write = en && r_d_vld && r_d_mode == MODE_INSERT && !d_full;

    // sweep owns the write port while clearing
    assign ram_we    = r_clr_busy || d_write;
    assign ram_waddr = r_clr_busy ? r_clr_addr : r_d_addr;
    assign ram_wdata = r_clr_busy ? NO_HEAD : LINK_W'(r_count);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_fwd_addr <= r_d_addr;
            r_fwd_data <= LINK_W'(r_count);
        end
    end

    // result register payload
    logic [NUM_W-1:0]  r_out_num;
    logic [RC_W-1:0]   r_out_col, r_out_row;
    logic [LINK_W-1:0] r_out_link;
    logic              r_out_full;

    always_ff @(posedge i_clk) begin
        if (en && r_d_vld) begin
            unique case (r_d_mode)
                MODE_INSERT: begin
                    r_out_num  <= d_full ? '0 : NUM_W'(r_count);
                    r_out_col  <= r_d_col;
                    r_out_row  <= r_d_row;
                    r_out_link <= d_full ? NO_HEAD : head;
                    r_out_full <= d_full;
                end
                MODE_QUERY: begin
                    r_out_num  <= '0;
                    r_out_col  <= r_d_col;
                    r_out_row  <= r_d_row;
                    r_out_link <= r_d_inq ? head : NO_HEAD;
                    r_out_full <= 1'b0;
                end
                default: begin
                    r_out_num  <= '0;
                    r_out_col  <= '0;
                    r_out_row  <= '0;
                    r_out_link <= NO_HEAD;
                    r_out_full <= 1'b0;
                end
            endcase
        end
    end

    // control state: valids, count, sweep, bypass
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld    <= 1'b0;
            r_b_vld    <= 1'b0;
            r_d_vld    <= 1'b0;
            r_out_vld  <= 1'b0;
            r_fwd_vld  <= 1'b0;
            r_count    <= '0;
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else begin
            if (en) begin
                r_a_vld   <= in_take;
                r_b_vld   <= r_a_vld;
                r_d_vld   <= r_b_vld;
                r_out_vld <= r_d_vld;
                r_fwd_vld <= d_write;
            end
            if (d_write) begin
                r_count <= r_count + CNT_W'(1);
            end
            // clear request at the last stage: reset count, start sweep
            if (en && r_d_vld && r_d_mode == MODE_CLEAR) begin
                r_count    <= '0;
                r_clr_busy <= 1'b1;
                r_clr_addr <= '0;
            end else if (r_clr_busy) begin
                if (r_clr_addr == AW'(CELLS - 1)) begin
                    r_clr_busy <= 1'b0;
                end else begin
                    r_clr_addr <= r_clr_addr + AW'(1);
                end
            end
        end
    end

    assign o_out_valid       = r_out_vld;
    assign o_particle_number = r_out_num;
    assign o_cell_col        = r_out_col;
    assign o_cell_row        = r_out_row;
    assign o_link            = r_out_link;
    assign o_full_res        = r_out_full;

`ifndef SYNTHESIS
    // no request enters while the table is being swept
    a_no_take_in_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_busy |-> !o_in_ready)
        else $error("request taken during table sweep");

    // an insert never competes with the sweep for the write port
    a_no_write_in_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_clr_busy && d_write))
        else $error("insert write during table sweep");

    // a clear reaching the last stage starts the sweep
    a_clear_starts_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (en && r_d_vld && r_d_mode == MODE_CLEAR) |=> (r_clr_busy && r_count == '0))
        else $error("clear did not start sweep");

    // a refused insert reports no number and an empty link
    a_full_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_full_res) |-> (o_particle_number == '0 && o_link == NO_HEAD))
        else $error("full result carries data");

    // the particle count never passes capacity
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (32'(r_count) <= MAX_PARTICLES))
        else $error("particle count beyond capacity");
`endif

endmodule
`default_nettype wire
